@@ hdl/nmea_sentence_framer_ring_core_macros.svh @@
// ----------------------------------------------------------------------------
// NMEA sentence framer ring - assertion macros
// Shared concurrent assertion wrappers. They expect clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_FRAMER_RING_CORE_MACROS_SVH
`define NMEA_SENTENCE_FRAMER_RING_CORE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define NSFR_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// A consequence in the same cycle.
`define NSFR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A consequence in the following cycle.
`define NSFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/nsfr_pkg.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence framer ring - package
// Sizes, character codes, operation codes and the structs passed between the
// front end and the back end.
// ----------------------------------------------------------------------------
package nsfr_pkg;

  localparam int SLOTS        = 16;
  localparam int MAX_SENTENCE = 80;
  localparam int STORE_DEPTH  = SLOTS * MAX_SENTENCE;

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int FILL_W  = 7;
  localparam int BYTE_W  = 8;
  localparam int PEND_W  = 5;

  localparam logic [BYTE_W-1:0] START_CHAR = 8'h24;
  localparam logic [BYTE_W-1:0] END_CHAR   = 8'h0A;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_PEEK    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic              is_start;
    logic              is_end;
    logic [BYTE_W-1:0] rx_byte;
    logic [FILL_W-1:0] peek_offset;
  } cmd_t;

  typedef struct packed {
    logic              release_error;
    logic              overflow_toggle;
    logic              sentence_dropped;
    logic              sentence_done;
    logic [PEND_W-1:0] pending_count;
    logic [FILL_W-1:0] oldest_length;
    logic [BYTE_W-1:0] peek_data;
  } res_t;

endpackage

@@ hdl/nsfr_ram.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence framer ring - generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nsfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1280
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/nsfr_front.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence framer ring - front end
// Accepts input transfers, marks the framing characters and holds the
// commands in a two-entry queue in front of the back end.
// ----------------------------------------------------------------------------
module nsfr_front import nsfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        in_op_i,
  input  logic [BYTE_W-1:0] in_rx_byte_i,
  input  logic [FILL_W-1:0] in_peek_offset_i,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  input  logic              cmd_ready_i
);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  cmd_t              queue_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  cmd_t              cmd_new;
  logic              push, pop;

  always_comb begin
    cmd_new.op          = op_e'(in_op_i);
    cmd_new.is_start    = (in_rx_byte_i == START_CHAR);
    cmd_new.is_end      = (in_rx_byte_i == END_CHAR);
    cmd_new.rx_byte     = in_rx_byte_i;
    cmd_new.peek_offset = in_peek_offset_i;
  end

  assign in_ready_o  = (count_q != QCNT_W'(QDEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_ready_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

@@ hdl/nsfr_back.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence framer ring - back end
// Runs the framing state, the slot ring and the sentence store, and holds
// the result register toward the output.
// ----------------------------------------------------------------------------
`include "nmea_sentence_framer_ring_core_macros.svh"

module nsfr_back import nsfr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_ready_o,
  output logic res_valid_o,
  output res_t res_o,
  input  logic res_ready_i
);

  typedef enum logic [1:0] {
    ST_EXEC   = 2'b01,
    ST_REPORT = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic              coll_q, coll_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [SLOT_W-1:0] wslot_q, wslot_d;
  logic [SLOT_W-1:0] rslot_q, rslot_d;
  logic [CNT_W-1:0]  wait_q, wait_d;
  logic              ovf_q, ovf_d;
  logic              done_q, done_d;
  logic              drop_q, drop_d;
  logic              err_q, err_d;
  logic              hit_q, hit_d;
  logic              out_valid_q, out_valid_d;
  res_t              res_q, res_d;
  logic [FILL_W-1:0] len_q [SLOTS];

  logic              go, out_free;
  logic              len_we;
  logic              ram_we, ram_re;
  logic [FILL_W-1:0] wr_offset;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic              peek_hit;

  assign out_free    = !out_valid_q || res_ready_i;
  assign go          = (state_q == ST_EXEC) && cmd_valid_i && out_free;
  assign cmd_ready_o = go;

  // Offset and slot limits on a peek; an empty ring never hits.
  assign peek_hit = (wait_q != '0) && (cmd_i.peek_offset < len_q[rslot_q]) &&
                    ({1'b0, cmd_i.peek_offset} < (FILL_W + 1)'(MAX_SENTENCE));

  assign ram_waddr = ADDR_W'(wslot_q) * ADDR_W'(MAX_SENTENCE) + ADDR_W'(wr_offset);
  assign ram_raddr = ADDR_W'(rslot_q) * ADDR_W'(MAX_SENTENCE) + ADDR_W'(cmd_i.peek_offset);
  assign ram_re    = go && (cmd_i.op == OP_PEEK) && peek_hit;

  always_comb begin
    state_d     = state_q;
    coll_d      = coll_q;
    fill_d      = fill_q;
    wslot_d     = wslot_q;
    rslot_d     = rslot_q;
    wait_d      = wait_q;
    ovf_d       = ovf_q;
    done_d      = done_q;
    drop_d      = drop_q;
    err_d       = err_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    len_we      = 1'b0;
    ram_we      = 1'b0;
    wr_offset   = fill_q;

    if (out_valid_q && res_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_EXEC: begin
        if (go) begin
          state_d = ST_REPORT;
          done_d  = 1'b0;
          drop_d  = 1'b0;
          err_d   = 1'b0;
          hit_d   = 1'b0;
          unique case (cmd_i.op)
            OP_BYTE: begin
              if (!coll_q) begin
                if (cmd_i.is_start) begin
                  ram_we    = 1'b1;
                  wr_offset = '0;
                  fill_d    = FILL_W'(1);
                  coll_d    = 1'b1;
                end
              end else if (cmd_i.is_start) begin
                // A new start character throws away the partial sentence.
                drop_d    = 1'b1;
                ram_we    = 1'b1;
                wr_offset = '0;
                fill_d    = FILL_W'(1);
              end else if (cmd_i.is_end) begin
                ram_we  = 1'b1;
                len_we  = 1'b1;
                coll_d  = 1'b0;
                fill_d  = '0;
                done_d  = 1'b1;
                wslot_d = (wslot_q == SLOT_W'(SLOTS - 1)) ? '0 : wslot_q + 1'b1;
                // A commit into a full ring restarts the count at one.
                if (wait_q >= CNT_W'(SLOTS)) begin
                  ovf_d  = !ovf_q;
                  wait_d = CNT_W'(1);
                end else begin
                  wait_d = wait_q + 1'b1;
                end
              end else begin
                ram_we = 1'b1;
                fill_d = fill_q + 1'b1;
              end
              if (fill_d == FILL_W'(MAX_SENTENCE - 1)) begin
                fill_d = '0;
                coll_d = 1'b0;
                drop_d = 1'b1;
              end
            end
            OP_PEEK: begin
              hit_d = peek_hit;
            end
            OP_RELEASE: begin
              if (wait_q == '0) begin
                err_d = 1'b1;
              end else begin
                rslot_d = (rslot_q == SLOT_W'(SLOTS - 1)) ? '0 : rslot_q + 1'b1;
                wait_d  = wait_q - 1'b1;
              end
            end
            OP_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_REPORT: begin
        state_d                = ST_EXEC;
        out_valid_d            = 1'b1;
        res_d.peek_data        = hit_q ? ram_rdata : '0;
        res_d.oldest_length    = (wait_q != '0) ? len_q[rslot_q] : '0;
        res_d.pending_count    = PEND_W'(wait_q);
        res_d.sentence_done    = done_q;
        res_d.sentence_dropped = drop_q;
        res_d.overflow_toggle  = ovf_q;
        res_d.release_error    = err_q;
      end
      default: begin
        state_d = ST_EXEC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_EXEC;
      coll_q      <= 1'b0;
      fill_q      <= '0;
      wslot_q     <= '0;
      rslot_q     <= '0;
      wait_q      <= '0;
      ovf_q       <= 1'b0;
      done_q      <= 1'b0;
      drop_q      <= 1'b0;
      err_q       <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        len_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      coll_q      <= coll_d;
      fill_q      <= fill_d;
      wslot_q     <= wslot_d;
      rslot_q     <= rslot_d;
      wait_q      <= wait_d;
      ovf_q       <= ovf_d;
      done_q      <= done_d;
      drop_q      <= drop_d;
      err_q       <= err_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      if (len_we) begin
        len_q[wslot_q] <= fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  nsfr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(cmd_i.rx_byte),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  `NSFR_ASSERT_ALWAYS(a_wait_bound, wait_q <= CNT_W'(SLOTS), "pending count above ring size")
  `NSFR_ASSERT_ALWAYS(a_fill_limit, fill_q != FILL_W'(MAX_SENTENCE - 1), "fill rests at limit")
  `NSFR_ASSERT_IMPL(a_idle_fill, !coll_q, fill_q == '0, "idle framer holds a fill length")
  `NSFR_ASSERT_NEXT(a_rel_empty, go && cmd_i.op == OP_RELEASE && wait_q == '0, err_q && $stable(rslot_q), "release on empty ring moved the read slot")
  `NSFR_ASSERT_NEXT(a_exec_report, go, state_q == ST_REPORT && !out_valid_q, "accepted command not reported")

endmodule

@@ hdl/nmea_sentence_framer_ring_core.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence framer ring - top level
// Frames received bytes into NMEA sentences kept in a ring of slots, and
// serves peeks and releases of the oldest sentence.
// ----------------------------------------------------------------------------
//  channel  | direction | tuser     | tdata (lowest bit first)
//  s_axis   | in        | op [1:0]  | rx_byte [7:0], peek_offset [14:8]
//  m_axis   | out       | -         | peek_data, oldest_length, pending_count,
//           |           |           | sentence_done, sentence_dropped,
//           |           |           | overflow_toggle, release_error
//
// In the back end each transfer passes through ST_EXEC, which updates the
// framing and ring state and launches the store read, and then ST_REPORT,
// which loads the result register. No new transfer is taken before the last
// is reported, as set by that sequencer and the registered read of the
// sentence store. A two-entry queue lets the input keep accepting while a
// result waits on m_axis_tready. After reset the ring is empty; the sentence
// store has no clearing pass and is read only where it was written.
// ----------------------------------------------------------------------------
module nmea_sentence_framer_ring_core import nsfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // rx_byte [7:0], peek_offset [14:8], zero [15]
  input  logic [1:0]  s_axis_tuser,   // op [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // peek_data [7:0], oldest_length [14:8],
                                      // pending_count [19:15], sentence_done [20],
                                      // sentence_dropped [21], overflow_toggle [22],
                                      // release_error [23]
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  res_t res;

  nsfr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .in_op_i         (s_axis_tuser),
    .in_rx_byte_i    (s_axis_tdata[7:0]),
    .in_peek_offset_i(s_axis_tdata[14:8]),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_ready_i     (cmd_ready)
  );

  nsfr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_ready_o(cmd_ready),
    .res_valid_o(m_axis_tvalid),
    .res_o      (res),
    .res_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = res;

endmodule
